@@ hw/rtl/mpwa_pkg.sv @@
// ----------------------------------------------------------------------------
// mpwa_pkg: shared types and constants of the max-pooling engine
// Holds configuration register indexes, command codes, the clamped
// configuration bundle, the scan sequencer states and its status bundle.
// ----------------------------------------------------------------------------
package mpwa_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned COORD_W  = 6;   // row and column of an item
  localparam int unsigned IDX_W    = 6;   // kernel index of a result
  localparam int unsigned CFG_IDX_W = 4;  // configuration register index
  localparam int unsigned CFG_DAT_W = 7;  // widest configuration register
  // Signed window coordinate: row*step + kernel offset - padding.
  localparam int unsigned POS_W    = 11;
  // Product of a coordinate and a step.
  localparam int unsigned PROD_W   = 10;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_ROWS      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_COLS      = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_ROWS     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_COLS     = 4'd7;

  // Command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration after clamping to the legal ranges.
  typedef struct packed {
    logic [6:0] img_h;
    logic [6:0] img_w;
    logic [3:0] win_h;
    logic [3:0] win_w;
    logic [2:0] pad_h;
    logic [2:0] pad_w;
    logic [3:0] st_h;
    logic [3:0] st_w;
  } cfg_t;

  // Scan sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CHECK,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } scan_state_e;

  // Status handed from the scan sequencer to the top level.
  typedef struct packed {
    logic             busy;
    logic             done;
    logic             range_error;
    logic [IDX_W-1:0] max_index;
  } scan_stat_t;

endpackage

@@ hw/rtl/mpwa_cfg.sv @@
// ----------------------------------------------------------------------------
// mpwa_cfg: configuration registers
// Eight small registers written through a valid/ready channel, presented
// to the datapath already clamped to their legal ranges.
// ----------------------------------------------------------------------------
module mpwa_cfg import mpwa_pkg::*; #(
  parameter int unsigned MAX_ROWS   = 64,
  parameter int unsigned MAX_COLS   = 64,
  parameter int unsigned MAX_WINDOW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output cfg_t                 cfg_o
);

  logic [6:0] img_h_q, img_w_q;
  logic [3:0] win_h_q, win_w_q, st_h_q, st_w_q;
  logic [2:0] pad_h_q, pad_w_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_h_q <= 7'd64;
      img_w_q <= 7'd64;
      win_h_q <= 4'd2;
      win_w_q <= 4'd2;
      pad_h_q <= 3'd0;
      pad_w_q <= 3'd0;
      st_h_q  <= 4'd2;
      st_w_q  <= 4'd2;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_IMAGE_HEIGHT:  img_h_q <= cfg_data_i;
        REG_IMAGE_WIDTH:   img_w_q <= cfg_data_i;
        REG_WINDOW_HEIGHT: win_h_q <= cfg_data_i[3:0];
        REG_WINDOW_WIDTH:  win_w_q <= cfg_data_i[3:0];
        REG_PAD_ROWS:      pad_h_q <= cfg_data_i[2:0];
        REG_PAD_COLS:      pad_w_q <= cfg_data_i[2:0];
        REG_STEP_ROWS:     st_h_q  <= cfg_data_i[3:0];
        REG_STEP_COLS:     st_w_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // A zero size or step acts as one; sizes beyond the store or the kernel limit saturate.
  always_comb begin
    cfg_o = '0;
    if (img_h_q == '0)                  cfg_o.img_h = 7'd1;
    else if (32'(img_h_q) > MAX_ROWS)   cfg_o.img_h = 7'(MAX_ROWS);
    else                                cfg_o.img_h = img_h_q;
    if (img_w_q == '0)                  cfg_o.img_w = 7'd1;
    else if (32'(img_w_q) > MAX_COLS)   cfg_o.img_w = 7'(MAX_COLS);
    else                                cfg_o.img_w = img_w_q;
    if (win_h_q == '0)                  cfg_o.win_h = 4'd1;
    else if (32'(win_h_q) > MAX_WINDOW) cfg_o.win_h = 4'(MAX_WINDOW);
    else                                cfg_o.win_h = win_h_q;
    if (win_w_q == '0)                  cfg_o.win_w = 4'd1;
    else if (32'(win_w_q) > MAX_WINDOW) cfg_o.win_w = 4'(MAX_WINDOW);
    else                                cfg_o.win_w = win_w_q;
    cfg_o.pad_h = pad_h_q;
    cfg_o.pad_w = pad_w_q;
    cfg_o.st_h  = (st_h_q == '0) ? 4'd1 : st_h_q;
    cfg_o.st_w  = (st_w_q == '0) ? 4'd1 : st_w_q;
  end

endmodule

@@ hw/rtl/mpwa_store.sv @@
// ----------------------------------------------------------------------------
// mpwa_store: pixel memory
// Synchronous memory with one write port and one read port; read data
// is registered and appears in the cycle after the read request.
// ----------------------------------------------------------------------------
module mpwa_store #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned DATA_W = 16,
  parameter int unsigned ADDR_W = 12
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

@@ hw/rtl/mpwa_scan.sv @@
// ----------------------------------------------------------------------------
// mpwa_scan: window scan sequencer
// Checks a query against the output grid, then walks the kernel window
// one position per cycle, issuing memory reads for in-bounds positions
// and folding the returned pixels into a running maximum and its index.
// ----------------------------------------------------------------------------
module mpwa_scan import mpwa_pkg::*; #(
  parameter int unsigned MAX_COLS   = 64,
  parameter int unsigned PIXEL_BITS = 16,
  parameter int unsigned ADDR_W     = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cfg_t                         cfg_i,
  input  logic                         go_i,
  input  logic [COORD_W-1:0]           row_i,
  input  logic [COORD_W-1:0]           col_i,
  output logic                         rd_en_o,
  output logic [ADDR_W-1:0]            rd_addr_o,
  input  logic signed [PIXEL_BITS-1:0] rd_data_i,
  output logic signed [PIXEL_BITS-1:0] max_value_o,
  output scan_stat_t                   stat_o
);

  localparam logic signed [PIXEL_BITS-1:0] PIX_MIN = {1'b1, {(PIXEL_BITS-1){1'b0}}};

  scan_state_e st_q, st_d;

  logic [COORD_W-1:0]           row_q, col_q;
  logic [PROD_W-1:0]            prod_h_q, prod_w_q;
  logic signed [POS_W-1:0]      base_h_q, base_w_q;
  logic [3:0]                   ii_q, jj_q;
  logic [IDX_W-1:0]             kidx_q;
  logic                         pend_vld_q;
  logic [IDX_W-1:0]             pend_idx_q;
  logic signed [PIXEL_BITS-1:0] best_q;
  logic [IDX_W-1:0]             best_idx_q;
  logic                         found_q;
  logic                         err_q;

  logic                         grid_err;
  logic signed [POS_W-1:0]      pos_h, pos_w;
  logic                         in_h, in_w, last_pos, row_end;

  // A query fits the grid when row*step + window <= image + 2*pad.
  assign grid_err =
      (11'(prod_h_q) + 11'(cfg_i.win_h) > 11'(cfg_i.img_h) + 11'({cfg_i.pad_h, 1'b0})) ||
      (11'(prod_w_q) + 11'(cfg_i.win_w) > 11'(cfg_i.img_w) + 11'({cfg_i.pad_w, 1'b0}));

  assign pos_h = base_h_q + signed'(POS_W'(ii_q));
  assign pos_w = base_w_q + signed'(POS_W'(jj_q));
  assign in_h  = !pos_h[POS_W-1] && (pos_h[POS_W-2:0] < 10'(cfg_i.img_h));
  assign in_w  = !pos_w[POS_W-1] && (pos_w[POS_W-2:0] < 10'(cfg_i.img_w));
  assign row_end  = (jj_q == cfg_i.win_w - 4'd1);
  assign last_pos = row_end && (ii_q == cfg_i.win_h - 4'd1);

  assign rd_addr_o = ADDR_W'(32'(pos_h[POS_W-2:0]) * MAX_COLS + 32'(pos_w[POS_W-2:0]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d    = st_q;
    rd_en_o = 1'b0;
    stat_o  = '0;
    stat_o.busy = (st_q != S_IDLE);
    case (st_q)
      S_IDLE:  if (go_i) st_d = S_MUL;
      S_MUL:   st_d = S_CHECK;
      S_CHECK: st_d = grid_err ? S_DONE : S_SCAN;
      S_SCAN: begin
        rd_en_o = in_h && in_w;
        if (last_pos) st_d = S_DRAIN;
      end
      S_DRAIN: st_d = S_DONE;
      S_DONE: begin
        stat_o.done        = 1'b1;
        stat_o.range_error = err_q;
        stat_o.max_index   = best_idx_q;
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  assign max_value_o = best_q;

  // Control flags of the running maximum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      found_q    <= 1'b0;
      err_q      <= 1'b0;
    end else begin
      pend_vld_q <= rd_en_o;
      if (st_q == S_IDLE && go_i) begin
        found_q <= 1'b0;
        err_q   <= 1'b0;
      end else if (st_q == S_CHECK && grid_err) begin
        err_q   <= 1'b1;
      end else if (pend_vld_q) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= kidx_q;
    case (st_q)
      S_IDLE: begin
        if (go_i) begin
          row_q      <= row_i;
          col_q      <= col_i;
          best_q     <= PIX_MIN;
          best_idx_q <= '0;
        end
      end
      S_MUL: begin
        prod_h_q <= PROD_W'(row_q * cfg_i.st_h);
        prod_w_q <= PROD_W'(col_q * cfg_i.st_w);
      end
      S_CHECK: begin
        base_h_q <= signed'(POS_W'(prod_h_q)) - signed'(POS_W'(cfg_i.pad_h));
        base_w_q <= signed'(POS_W'(prod_w_q)) - signed'(POS_W'(cfg_i.pad_w));
        ii_q     <= '0;
        jj_q     <= '0;
        kidx_q   <= '0;
        if (grid_err) begin
          best_q <= '0;
        end
      end
      S_SCAN: begin
        kidx_q <= kidx_q + 1'b1;
        if (row_end) begin
          jj_q <= '0;
          ii_q <= ii_q + 4'd1;
        end else begin
          jj_q <= jj_q + 4'd1;
        end
      end
      default: ;
    endcase
    // The first in-bounds pixel always takes the lead; later ones only when
    // strictly larger, so ties keep the first index.
    if (pend_vld_q && (!found_q || rd_data_i > best_q)) begin
      best_q     <= rd_data_i;
      best_idx_q <= pend_idx_q;
    end
  end

`ifndef ASSERT_OFF
  a_pend_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> (st_q == S_SCAN || st_q == S_DRAIN))
    else $error("memory read outstanding outside of a window scan");
  a_check_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_CHECK |=> (st_q == S_DONE && err_q) || (st_q == S_SCAN && !err_q))
    else $error("grid check did not resolve to scan or error");
  a_empty_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DONE && !err_q && !found_q) |-> (best_q == PIX_MIN && best_idx_q == '0))
    else $error("empty window did not report the most negative value");
`endif

endmodule

@@ hw/rtl/max_pool_window_argmax.sv @@
// ----------------------------------------------------------------------------
// max_pool_window_argmax: 2D max pooling with argmax over a stored plane
// Pixel writes fill an internal store; queries scan one pooling window
// and return its maximum and the kernel index of the first maximum.
// ----------------------------------------------------------------------------
// A write beat puts its pixel into the store at the accepting edge, and its
// result strobes on done_o in the next cycle, so writes may be issued back
// to back. A query beat runs through a sequencer that owns the single read
// port of the pixel store: two setup states (multiply by the stride, then
// check against the output grid), one kernel position per cycle
// (window_height * window_width positions, padding positions included), a
// drain state for the last read to return and a done state to finish. Its
// result strobes in the cycle after the done state, and busy_o stays high
// until the cycle before that strobe, so a new query is taken only once the
// last one is through; a query outside the output grid goes from the check
// state straight to the done state. The receiver cannot stall: each
// result is on max_value_o, max_index_o and range_error_o for exactly the
// one cycle in which done_o is high. Configuration is taken on any cycle
// (cfg_ready_o is always high) but must only change while the block is
// idle. The pixel store has no reset; a query must only touch pixels that
// were written before.
// ----------------------------------------------------------------------------
module max_pool_window_argmax import mpwa_pkg::*; #(
  parameter int unsigned MAX_ROWS   = 64,
  parameter int unsigned MAX_COLS   = 64,
  parameter int unsigned MAX_WINDOW = 8,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write channel.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DAT_W-1:0]         cfg_data_i,
  // Command channel.
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         cmd_i,
  input  logic [COORD_W-1:0]           row_i,
  input  logic [COORD_W-1:0]           col_i,
  input  logic signed [PIXEL_BITS-1:0] pixel_value_i,
  // Result strobe.
  output logic                         done_o,
  output logic signed [PIXEL_BITS-1:0] max_value_o,
  output logic [IDX_W-1:0]             max_index_o,
  output logic                         range_error_o
);

  localparam int unsigned DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t                         cfg;
  scan_stat_t                   scan_stat;
  logic signed [PIXEL_BITS-1:0] scan_value;
  logic signed [PIXEL_BITS-1:0] rd_data;
  logic                         rd_en;
  logic [ADDR_W-1:0]            rd_addr;
  logic                         accept, wr_accept, wr_ok, scan_go;
  logic [ADDR_W-1:0]            wr_addr;

  logic                         done_q;
  logic signed [PIXEL_BITS-1:0] value_q;
  logic [IDX_W-1:0]             index_q;
  logic                         err_q;

  mpwa_cfg #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // A beat is taken whenever the scan sequencer is idle.
  assign busy_o    = scan_stat.busy;
  assign accept    = start_i && !busy_o;
  assign wr_accept = accept && (cmd_i == CMD_WRITE);
  assign scan_go   = accept && (cmd_i == CMD_QUERY);

  // Writes outside the configured plane are dropped and flagged.
  assign wr_ok   = (7'(row_i) < cfg.img_h) && (7'(col_i) < cfg.img_w);
  assign wr_addr = ADDR_W'(32'(row_i) * MAX_COLS + 32'(col_i));

  mpwa_store #(
    .DEPTH  (DEPTH),
    .DATA_W (PIXEL_BITS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_accept && wr_ok),
    .wr_addr_i (wr_addr),
    .wr_data_i (pixel_value_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  mpwa_scan #(
    .MAX_COLS   (MAX_COLS),
    .PIXEL_BITS (PIXEL_BITS),
    .ADDR_W     (ADDR_W)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .go_i        (scan_go),
    .row_i       (row_i),
    .col_i       (col_i),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .max_value_o (scan_value),
    .stat_o      (scan_stat)
  );

  // Result register. A write result and a query result never meet here:
  // writes are only taken while the sequencer is idle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= wr_accept || scan_stat.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_accept) begin
      value_q <= '0;
      index_q <= '0;
      err_q   <= !wr_ok;
    end else if (scan_stat.done) begin
      // A query outside the grid carries zero from the sequencer.
      value_q <= scan_value;
      index_q <= scan_stat.range_error ? '0 : scan_stat.max_index;
      err_q   <= scan_stat.range_error;
    end
  end

  assign done_o        = done_q;
  assign max_value_o   = value_q;
  assign max_index_o   = index_q;
  assign range_error_o = err_q;

`ifndef ASSERT_OFF
  a_write_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_accept |=> done_o && !busy_o)
    else $error("write beat did not produce its result in the next cycle");
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_go |=> busy_o && !done_o)
    else $error("query beat did not occupy the sequencer");
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && range_error_o) |-> (max_value_o == '0 && max_index_o == '0))
    else $error("range error result carries nonzero payload");
`endif

endmodule
